// ===== rtl/core/gkg_pkg.sv =====
package gkg_pkg;

	localparam int unsigned MAX_SIDE_DEF = 7;
	localparam int unsigned STORE_DEPTH  = 64;
	localparam int unsigned IDX_W        = 6;
	localparam int unsigned W_W          = 24;
	localparam int unsigned SUM_W        = 32;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_SIGMA = 2'd1;
	localparam logic [1:0] ST_BAD_SIZE  = 2'd2;

	// exp(-1) in Q0.32, as the 14-term truncated series gives it
	localparam logic [32:0] EXP_M1_Q32 = 33'd1580030169;

	typedef struct packed {
		logic [15:0] sigma;
		logic [2:0]  kernel_size;
	} req_t;

	typedef struct packed {
		logic [15:0] coefficient;
		logic [2:0]  row;
		logic [2:0]  column;
		logic        last;
		logic [1:0]  status;
	} res_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ERR,
		S_CELL,
		S_DIVA,
		S_WAITA,
		S_TAYLOR,
		S_POW,
		S_STORE,
		S_RD,
		S_RDW,
		S_DIVC,
		S_WAITC,
		S_EMIT
	} state_t;

endpackage

// ===== rtl/core/gkg_div.sv =====
// restoring divider, one quotient bit per cycle
module gkg_div #(
	parameter int unsigned NW = 64,
	parameter int unsigned DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int unsigned CW = $clog2(NW + 1);

	gkg_pkg::div_state_t st_q;
	logic [NW-1:0] n_q;
	logic [DW:0]   r_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   trial;
	logic [DW:0]   rsh;

	assign rsh   = {r_q[DW-1:0], n_q[NW-1]};
	assign trial = rsh - {1'b0, d_q};
	assign done  = (st_q == gkg_pkg::DIV_DONE);
	assign quo   = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= gkg_pkg::DIV_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (st_q)
				gkg_pkg::DIV_IDLE: if (go) begin
					st_q  <= gkg_pkg::DIV_RUN;
					cnt_q <= CW'(NW);
				end
				gkg_pkg::DIV_RUN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) st_q <= gkg_pkg::DIV_DONE;
				end
				gkg_pkg::DIV_DONE: st_q <= gkg_pkg::DIV_IDLE;
				default: st_q <= gkg_pkg::DIV_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == gkg_pkg::DIV_IDLE && go) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (st_q == gkg_pkg::DIV_RUN) begin
			if (!trial[DW]) begin
				r_q <= trial;
				n_q <= {n_q[NW-2:0], 1'b1};
			end else begin
				r_q <= rsh;
				n_q <= {n_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule

// ===== rtl/core/gkg_mac.sv =====
// shared 33x33 multiplier with a registered product; no add or shift is applied here
module gkg_mac (
	input  logic        clk,
	input  logic [32:0] a,
	input  logic [32:0] b,
	output logic [65:0] p_q
);
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end
endmodule

// ===== rtl/core/gaussian_kernel_generator.sv =====
// gaussian_kernel_generator
// request channel: raise start with req (sigma Q8.8, kernel_size) while busy is
//   low; the request is taken at that edge and busy rises on the next cycle
// result channel: one result per cycle-wide strobe, raster order, last on the
//   final coefficient; the receiver cannot stall, so results are never held
// zero sigma or zero size: a single error result, strobed once the request has
//   passed through the error state
// per cell: the weight takes an exponent divide, a 14-step taylor sum on the
//   multiplier (each step a multiply by the fraction, a reciprocal multiply
//   by 1/k and an accumulate) and n exp(-1) multiplies with n up to 31; the
//   normalize pass then takes a normalizing divide and the strobe
// throughput: one request at a time; busy falls as the last result is strobed.
//   the single bit-serial divider and the single multiplier, shared across
//   every cell of the request, set the rate
// weights sit in a 64 x 24 memory, written during the weight pass and read
//   back during the normalize pass; no clearing is needed
// reset: asynchronous active low, returns to idle with busy low, no strobe
module gaussian_kernel_generator #(
	parameter int unsigned MAX_SIDE = gkg_pkg::MAX_SIDE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  gkg_pkg::req_t req,
	output logic          busy,
	output logic          strobe,
	output gkg_pkg::res_t res
);
	localparam logic [2:0] LIMIT = 3'((MAX_SIDE % 2 == 0) ? MAX_SIDE - 1 : MAX_SIDE);

	gkg_pkg::state_t st_q, st_d;

	logic [31:0] sig2_q;
	logic [2:0]  side_q, center_q, y_q, x_q;
	logic [1:0]  err_q;
	logic [4:0]  n_q, i_q;
	logic [3:0]  k_q;
	logic        ph_q;
	logic [1:0]  tph_q;
	logic [23:0] f_q;
	logic [32:0] term_q, v_q;
	logic signed [34:0] acc_q;
	logic [31:0] sum_q;
	logic [23:0] rd_q;
	logic [23:0] mem_q [gkg_pkg::STORE_DEPTH];
	logic [5:0]  idx;
	gkg_pkg::res_t res_q;
	logic        strobe_q;

	// divider
	logic        dgo;
	logic [63:0] dnum;
	logic [31:0] dden;
	logic        ddone;
	logic [63:0] dquo;
	// multiplier
	logic [32:0] ma, mb;
	logic [65:0] mp;

	logic [2:0] dy, dx;
	logic [5:0] d2;
	logic [2:0] side_in;
	logic [33:0] tq;
	logic [32:0] vr;
	logic [32:0] acc_sat;
	logic [23:0] wnew;
	logic [16:0] cq;
	// reciprocal of k for the taylor divide: multiplier and shift
	logic [32:0] rcp_m;
	logic [5:0]  rcp_s;
	logic [32:0] qk;

	gkg_div #(.NW(64), .DW(32)) u_div (
		.clk(clk), .arst_n(arst_n), .go(dgo), .num(dnum), .den(dden),
		.done(ddone), .quo(dquo)
	);

	gkg_mac u_mac (.clk(clk), .a(ma), .b(mb), .p_q(mp));

	assign dy  = (y_q > center_q) ? y_q - center_q : center_q - y_q;
	assign dx  = (x_q > center_q) ? x_q - center_q : center_q - x_q;
	assign d2  = {3'd0, dx} * {3'd0, dx} + {3'd0, dy} * {3'd0, dy};
	assign idx = {3'd0, y_q} * {3'd0, side_q} + {3'd0, x_q};

	always_comb begin
		side_in = req.kernel_size | 3'd1;
		if (side_in > LIMIT) side_in = LIMIT;
	end

	// divider operand select: exponent pass or normalize pass
	always_comb begin
		dgo  = (st_q == gkg_pkg::S_DIVA) || (st_q == gkg_pkg::S_DIVC);
		if (st_q == gkg_pkg::S_DIVC) begin
			dnum = {24'd0, rd_q, 16'd0} + {33'd0, sum_q[31:1]};
			dden = sum_q;
		end else begin
			dnum = {19'd0, d2, 39'd0} + {33'd0, sig2_q[31:1]};
			dden = sig2_q;
		end
	end

	// floor(x/k) = (x*m) >> s, exact for any x below 2^32
	always_comb begin
		case (k_q)
			4'd2: begin
				rcp_m = 33'd4294967297;
				rcp_s = 6'd33;
			end
			4'd3: begin
				rcp_m = 33'd5726623062;
				rcp_s = 6'd34;
			end
			4'd4: begin
				rcp_m = 33'd4294967297;
				rcp_s = 6'd34;
			end
			4'd5: begin
				rcp_m = 33'd6871947674;
				rcp_s = 6'd35;
			end
			4'd6: begin
				rcp_m = 33'd5726623062;
				rcp_s = 6'd35;
			end
			4'd7: begin
				rcp_m = 33'd4908534053;
				rcp_s = 6'd35;
			end
			4'd8: begin
				rcp_m = 33'd4294967297;
				rcp_s = 6'd35;
			end
			4'd9: begin
				rcp_m = 33'd7635497416;
				rcp_s = 6'd36;
			end
			4'd10: begin
				rcp_m = 33'd6871947674;
				rcp_s = 6'd36;
			end
			4'd11: begin
				rcp_m = 33'd6247225158;
				rcp_s = 6'd36;
			end
			4'd12: begin
				rcp_m = 33'd5726623062;
				rcp_s = 6'd36;
			end
			4'd13: begin
				rcp_m = 33'd5286113596;
				rcp_s = 6'd36;
			end
			4'd14: begin
				rcp_m = 33'd4908534053;
				rcp_s = 6'd36;
			end
			default: begin
				rcp_m = 33'd4294967297;
				rcp_s = 6'd32;
			end
		endcase
	end

	// multiplier operand select: taylor term, reciprocal step or exp(-1) power step
	always_comb begin
		if (st_q == gkg_pkg::S_POW) begin
			ma = (i_q == '0) ? acc_sat : v_q;
			mb = gkg_pkg::EXP_M1_Q32;
		end else if (st_q == gkg_pkg::S_TAYLOR && tph_q == 2'd1) begin
			ma = tq[32:0];
			mb = rcp_m;
		end else begin
			ma = term_q;
			mb = {9'd0, f_q};
		end
	end

	assign tq      = 34'(mp >> 24);
	assign qk      = 33'(mp >> rcp_s);
	assign vr      = 33'((mp + 66'(64'd1 << 31)) >> 32);
	assign acc_sat = acc_q[34] ? 33'd0 :
		(acc_q > 35'sd4294967296) ? 33'd4294967296 : 33'(acc_q);
	assign wnew    = 24'((v_q + 33'd256) >> 9);
	assign cq      = (dquo[63:16] != '0) ? 17'h0FFFF :
		((dquo[16]) ? 17'h0FFFF : dquo[16:0]);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			gkg_pkg::S_IDLE: if (start) begin
				if (req.sigma == '0 || req.kernel_size == '0) st_d = gkg_pkg::S_ERR;
				else st_d = gkg_pkg::S_CELL;
			end
			gkg_pkg::S_ERR:    st_d = gkg_pkg::S_IDLE;
			gkg_pkg::S_CELL:   st_d = gkg_pkg::S_DIVA;
			gkg_pkg::S_DIVA:   st_d = gkg_pkg::S_WAITA;
			gkg_pkg::S_WAITA:  if (ddone) st_d = gkg_pkg::S_TAYLOR;
			gkg_pkg::S_TAYLOR: if (tph_q == 2'd2 && k_q == 4'd14) st_d = gkg_pkg::S_POW;
			gkg_pkg::S_POW:    if (i_q == n_q && !ph_q) st_d = gkg_pkg::S_STORE;
			gkg_pkg::S_STORE: begin
				if (y_q == side_q - 1'b1 && x_q == side_q - 1'b1) st_d = gkg_pkg::S_RD;
				else st_d = gkg_pkg::S_CELL;
			end
			gkg_pkg::S_RD:     st_d = gkg_pkg::S_RDW;
			gkg_pkg::S_RDW:    st_d = gkg_pkg::S_DIVC;
			gkg_pkg::S_DIVC:   st_d = gkg_pkg::S_WAITC;
			gkg_pkg::S_WAITC:  if (ddone) st_d = gkg_pkg::S_EMIT;
			gkg_pkg::S_EMIT: begin
				if (y_q == side_q - 1'b1 && x_q == side_q - 1'b1) st_d = gkg_pkg::S_IDLE;
				else st_d = gkg_pkg::S_RD;
			end
			default: st_d = gkg_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		busy = (st_q != gkg_pkg::S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= gkg_pkg::S_IDLE;
			strobe_q <= 1'b0;
			sum_q    <= '0;
		end else begin
			st_q     <= st_d;
			strobe_q <= (st_q == gkg_pkg::S_ERR) || (st_q == gkg_pkg::S_EMIT);
			if (st_q == gkg_pkg::S_IDLE && start) sum_q <= '0;
			else if (st_q == gkg_pkg::S_STORE) sum_q <= sum_q + {8'd0, wnew};
		end
	end

	// weight memory
	always_ff @(posedge clk) begin
		if (st_q == gkg_pkg::S_STORE) mem_q[idx] <= wnew;
		if (st_q == gkg_pkg::S_RD) rd_q <= mem_q[idx];
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			gkg_pkg::S_IDLE: if (start) begin
				sig2_q   <= {16'd0, req.sigma} * {16'd0, req.sigma};
				side_q   <= side_in;
				center_q <= side_in >> 1;
				y_q      <= '0;
				x_q      <= '0;
				err_q    <= (req.sigma == '0) ? gkg_pkg::ST_BAD_SIGMA : gkg_pkg::ST_BAD_SIZE;
			end
			gkg_pkg::S_ERR: begin
				res_q <= '{coefficient: '0, row: '0, column: '0, last: 1'b1, status: err_q};
			end
			gkg_pkg::S_WAITA: if (ddone) begin
				n_q    <= (dquo[63:29] != '0) ? 5'd24 : dquo[28:24];
				f_q    <= dquo[23:0];
				term_q <= 33'h100000000;
				acc_q  <= 35'sd4294967296;
				k_q    <= 4'd1;
				ph_q   <= 1'b0;
				tph_q  <= 2'd0;
			end
			gkg_pkg::S_TAYLOR: begin
				tph_q <= (tph_q == 2'd2) ? 2'd0 : tph_q + 2'd1;
				if (tph_q == 2'd2) begin
					// term = ((term*f)>>24)/k via reciprocal multiply
					term_q <= qk;
					if (k_q[0]) acc_q <= acc_q - $signed({2'b0, qk});
					else        acc_q <= acc_q + $signed({2'b0, qk});
					k_q <= k_q + 1'b1;
					if (k_q == 4'd14) begin
						i_q  <= '0;
					end
				end
			end
			gkg_pkg::S_POW: begin
				ph_q <= ~ph_q;
				if (!ph_q && i_q == '0) v_q <= acc_sat;
				if (ph_q) begin
					v_q <= vr;
					i_q <= i_q + 1'b1;
				end
			end
			gkg_pkg::S_STORE: begin
				if (x_q == side_q - 1'b1) begin
					x_q <= '0;
					if (y_q != side_q - 1'b1) y_q <= y_q + 1'b1;
					else y_q <= '0;
				end else x_q <= x_q + 1'b1;
			end
			gkg_pkg::S_WAITC: if (ddone) begin
				res_q <= '{coefficient: cq[15:0], row: y_q, column: x_q,
					last: (y_q == side_q - 1'b1 && x_q == side_q - 1'b1),
					status: gkg_pkg::ST_OK};
			end
			gkg_pkg::S_EMIT: begin
				if (x_q == side_q - 1'b1) begin
					x_q <= '0;
					y_q <= y_q + 1'b1;
				end else x_q <= x_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign strobe = strobe_q;
	assign res    = res_q;
endmodule
